// ===== hdl/mscdt_pkg.sv =====
// Shared types, codes and helpers for the multi-slot countdown timer.
// No dependencies.
`timescale 1ns / 1ps

package mscdt_pkg;

    // Command codes
    localparam logic [1:0] CMD_ARM    = 2'd0;
    localparam logic [1:0] CMD_DISARM = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_EXPIRY = 3'd0;
    localparam logic [2:0] KIND_ARM    = 3'd1;
    localparam logic [2:0] KIND_DISARM = 3'd2;
    localparam logic [2:0] KIND_QUERY  = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    localparam logic [7:0] FREE_CHANNEL = 8'hFF;

    // Tick period: clamp(remaining / 10, 50, 1000)
    localparam logic [9:0]  PERIOD_MIN_MS = 10'd50;
    localparam logic [9:0]  PERIOD_MAX_MS = 10'd1000;
    localparam logic [31:0] REM_LOW       = 32'd500;    // below: period is minimum
    localparam logic [31:0] REM_HIGH      = 32'd10010;  // at or above: period is maximum
    localparam logic [15:0] DIV10_MUL     = 16'd52429;  // 2^19 / 10, rounded up
    localparam int          DIV10_SHIFT   = 19;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         channel;
        logic [7:0]         gpio;
        logic [31:0]        duration_ms;
        logic [63:0]        target_word;
        logic signed [31:0] requester;
        logic [63:0]        now_ms;
    } req_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic               ok;
        logic [7:0]         out_channel;
        logic [7:0]         out_gpio;
        logic [63:0]        out_target;
        logic signed [31:0] out_requester;
        logic [31:0]        remaining_ms;
        logic [9:0]         next_period_ms;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [7:0]         channel;
        logic [31:0]        remaining;
        logic [63:0]        stamp;
        logic [7:0]         pin;
        logic [63:0]        target;
        logic signed [31:0] sender;
    } slot_t;

    localparam slot_t SLOT_RESET = '{
        channel:   FREE_CHANNEL,
        remaining: 32'd0,
        stamp:     64'd0,
        pin:       8'd0,
        target:    64'd0,
        sender:    32'sd0
    };

    // Period from the smallest remaining time; the clamp is monotonic so
    // min(period) == period(min remaining).
    function automatic logic [9:0] period_of(input logic found, input logic [31:0] rem);
        logic [29:0] prod;
        logic [9:0]  res;
        begin
            prod = {16'd0, rem[13:0]} * {14'd0, DIV10_MUL};
            if (!found)
            begin
                res = 10'd0;
            end
            else if (rem < REM_LOW)
            begin
                res = PERIOD_MIN_MS;
            end
            else if (rem >= REM_HIGH)
            begin
                res = PERIOD_MAX_MS;
            end
            else
            begin
                res = prod[DIV10_SHIFT +: 10];
            end
            return res;
        end
    endfunction

endpackage

// ===== hdl/multi_slot_countdown_timer.sv =====
// Multi-slot countdown timer: slot table in one synchronous memory, walked per request.
// Depends on mscdt_pkg.
`timescale 1ns / 1ps

// Usage
//   Request channel (req_valid / req_stall / req): one command per request -
//   arm, disarm, tick or query. req_stall is high while a request is in work;
//   the block holds one request at a time.
//   Response channel (rsp_valid / rsp_stall / rsp): arm, disarm and query give
//   one response; a tick gives one expiry response per slot that runs out,
//   in slot order, then the tick-done response. The final response of every
//   request has last = 1 and carries the next tick period.
// Slot walk
//   The slot memory has one read port, so a request walks SLOTS entries, one per
//   cycle while no expiry waits on a busy output register. Arm writes its slot
//   after the walk; the next request is taken only once the final response is
//   loaded into the output register.
// Reset
//   rst_n clears the per-slot valid flags at once; an entry never written reads
//   as a free slot with all other fields zero. No clearing pass is needed.
// Stall
//   A response waits in the output register while rsp_stall is high. A tick
//   that has another expiry to report pauses on that slot until the register
//   frees up; nothing is lost or repeated.

module multi_slot_countdown_timer #(
    parameter int SLOTS = 8      // 1 .. 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  mscdt_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output mscdt_pkg::rsp_t  rsp
);

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_ARMWR = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // slot memory
    mscdt_pkg::slot_t mem [SLOTS];
    mscdt_pkg::slot_t rd_data_reg;
    logic             rd_vld_reg;
    logic [SLOTS-1:0] slot_vld_reg;
    logic             rd_en;
    logic [IDXW-1:0]  rd_addr;
    logic             wr_en;
    logic [IDXW-1:0]  wr_addr;
    mscdt_pkg::slot_t wr_data;

    // request context
    mscdt_pkg::req_t  cmd_reg;
    logic [IDXW-1:0]  idx_reg, idx_next;
    logic             match_found_reg, match_found_next;
    logic [IDXW-1:0]  hit_idx_reg, hit_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDXW-1:0]  free_idx_reg, free_idx_next;
    logic             ok_reg, ok_next;
    logic [63:0]      q_target_reg, q_target_next;
    logic signed [31:0] q_sender_reg, q_sender_next;
    logic [31:0]      q_rem_reg, q_rem_next;

    // running-minimum stage
    logic             cand_valid_reg, cand_valid_next;
    logic [31:0]      cand_rem_reg, cand_rem_next;
    logic             min_found_reg, min_found_next;
    logic [31:0]      min_rem_reg, min_rem_next;

    // output register
    logic             out_valid_reg;
    mscdt_pkg::rsp_t  out_reg;
    logic             out_free;
    logic             out_load;
    mscdt_pkg::rsp_t  out_data;

    // per-entry decode
    mscdt_pkg::slot_t ent;
    logic             is_match;
    logic             is_free;
    logic             running;
    logic [63:0]      diff;
    logic             expire;
    logic             hold;
    logic [2:0]       final_kind;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    assign ent      = rd_vld_reg ? rd_data_reg : mscdt_pkg::SLOT_RESET;
    assign is_match = (ent.channel == cmd_reg.channel);
    assign is_free  = (ent.channel == mscdt_pkg::FREE_CHANNEL);
    assign running  = !is_free && (ent.remaining != 32'd0);
    assign diff     = cmd_reg.now_ms - ent.stamp;
    assign expire   = (diff[63:32] != 32'd0) || (diff[31:0] >= ent.remaining);

    always_comb
    begin
        case (cmd_reg.command)
            mscdt_pkg::CMD_ARM:    final_kind = mscdt_pkg::KIND_ARM;
            mscdt_pkg::CMD_DISARM: final_kind = mscdt_pkg::KIND_DISARM;
            mscdt_pkg::CMD_TICK:   final_kind = mscdt_pkg::KIND_TICK;
            default:               final_kind = mscdt_pkg::KIND_QUERY;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg;
        wr_en            = 1'b0;
        wr_addr          = idx_reg;
        wr_data          = ent;
        match_found_next = match_found_reg;
        hit_idx_next     = hit_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        ok_next          = ok_reg;
        q_target_next    = q_target_reg;
        q_sender_next    = q_sender_reg;
        q_rem_next       = q_rem_reg;
        cand_valid_next  = 1'b0;
        cand_rem_next    = ent.remaining;
        min_found_next   = min_found_reg;
        min_rem_next     = min_rem_reg;
        out_load         = 1'b0;
        out_data         = '0;
        hold             = 1'b0;

        // fold the previous candidate into the minimum
        if (cand_valid_reg && (!min_found_reg || (cand_rem_reg < min_rem_reg)))
        begin
            min_found_next = 1'b1;
            min_rem_next   = cand_rem_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    rd_en            = 1'b1;
                    rd_addr          = '0;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    ok_next          = 1'b0;
                    q_target_next    = 64'd0;
                    q_sender_next    = 32'sd0;
                    q_rem_next       = 32'd0;
                    min_found_next   = 1'b0;
                    state_next       = ST_WALK;
                end
            end

            ST_WALK:
            begin
                case (cmd_reg.command)
                    mscdt_pkg::CMD_ARM:
                    begin
                        // the first match is overwritten, so it drops out of the minimum
                        if (!match_found_reg && is_match)
                        begin
                            match_found_next = 1'b1;
                            hit_idx_next     = idx_reg;
                        end
                        else
                        begin
                            cand_valid_next = running;
                        end
                        if (!free_found_reg && is_free)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                    mscdt_pkg::CMD_DISARM:
                    begin
                        if (!match_found_reg && is_match)
                        begin
                            match_found_next  = 1'b1;
                            wr_en             = 1'b1;
                            wr_data.channel   = mscdt_pkg::FREE_CHANNEL;
                            wr_data.remaining = 32'd0;
                            ok_next           = (ent.remaining != 32'd0);
                        end
                        else
                        begin
                            cand_valid_next = running;
                        end
                    end
                    mscdt_pkg::CMD_TICK:
                    begin
                        if (running)
                        begin
                            wr_en         = 1'b1;
                            wr_data.stamp = cmd_reg.now_ms;
                            if (expire)
                            begin
                                wr_data.remaining = 32'd0;
                                wr_data.channel   = mscdt_pkg::FREE_CHANNEL;
                                if (out_free)
                                begin
                                    out_load              = 1'b1;
                                    out_data.kind         = mscdt_pkg::KIND_EXPIRY;
                                    out_data.out_channel  = ent.channel;
                                    out_data.out_gpio     = ent.pin;
                                    out_data.out_target   = ent.target;
                                end
                                else
                                begin
                                    hold = 1'b1;
                                end
                            end
                            else
                            begin
                                wr_data.remaining = ent.remaining - diff[31:0];
                                cand_valid_next   = 1'b1;
                                cand_rem_next     = ent.remaining - diff[31:0];
                            end
                        end
                    end
                    default:
                    begin
                        // query: the last match wins
                        if (is_match)
                        begin
                            q_target_next = ent.target;
                            q_sender_next = ent.sender;
                            q_rem_next    = ent.remaining;
                        end
                        cand_valid_next = running;
                    end
                endcase

                if (hold)
                begin
                    // output busy: re-read this entry and retry
                    wr_en           = 1'b0;
                    cand_valid_next = 1'b0;
                    rd_en           = 1'b1;
                    rd_addr         = idx_reg;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = (cmd_reg.command == mscdt_pkg::CMD_ARM) ? ST_ARMWR : ST_FLUSH;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_ARMWR:
            begin
                wr_en   = match_found_reg || free_found_reg;
                wr_addr = match_found_reg ? hit_idx_reg : free_idx_reg;
                wr_data = '{
                    channel:   cmd_reg.channel,
                    remaining: cmd_reg.duration_ms,
                    stamp:     cmd_reg.now_ms,
                    pin:       cmd_reg.gpio,
                    target:    cmd_reg.target_word,
                    sender:    cmd_reg.requester
                };
                ok_next         = wr_en;
                cand_valid_next = wr_en && (cmd_reg.channel != mscdt_pkg::FREE_CHANNEL)
                                  && (cmd_reg.duration_ms != 32'd0);
                cand_rem_next   = cmd_reg.duration_ms;
                state_next      = ST_FLUSH;
            end

            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_load                = 1'b1;
                    out_data.kind           = final_kind;
                    out_data.ok             = ok_reg;
                    out_data.next_period_ms = mscdt_pkg::period_of(min_found_reg, min_rem_reg);
                    out_data.last           = 1'b1;
                    if (cmd_reg.command == mscdt_pkg::CMD_QUERY)
                    begin
                        out_data.out_channel   = cmd_reg.channel;
                        out_data.out_target    = q_target_reg;
                        out_data.out_requester = q_sender_reg;
                        out_data.remaining_ms  = q_rem_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            slot_vld_reg    <= '0;
            rd_vld_reg      <= 1'b0;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            hit_idx_reg     <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            ok_reg          <= 1'b0;
            cand_valid_reg  <= 1'b0;
            min_found_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            match_found_reg <= match_found_next;
            hit_idx_reg     <= hit_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            ok_reg          <= ok_next;
            cand_valid_reg  <= cand_valid_next;
            min_found_reg   <= min_found_next;
            if (wr_en)
            begin
                slot_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= slot_vld_reg[rd_addr];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            cmd_reg <= req;
        end
        q_target_reg <= q_target_next;
        q_sender_reg <= q_sender_next;
        q_rem_reg    <= q_rem_next;
        cand_rem_reg <= cand_rem_next;
        min_rem_reg  <= min_rem_next;
        if (out_load)
        begin
            out_reg <= out_data;
        end
    end

endmodule

// ===== hdl/mscdt_checker.sv =====
// Port-level checks for the multi-slot countdown timer, bound to the top level.
// Depends on mscdt_pkg and multi_slot_countdown_timer.
`timescale 1ns / 1ps

module mscdt_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_stall,
    input mscdt_pkg::req_t req,
    input logic            rsp_valid,
    input logic            rsp_stall,
    input mscdt_pkg::rsp_t rsp
);

    // one request in work at a time
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while another is in work");

    a_partial_is_expiry: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.kind == mscdt_pkg::KIND_EXPIRY)
        else $error("non-final response that is not an expiry");

    a_ack_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.kind != mscdt_pkg::KIND_EXPIRY |-> rsp.last)
        else $error("acknowledge response without last");

    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |->
            rsp.next_period_ms == 10'd0 ||
            (rsp.next_period_ms >= mscdt_pkg::PERIOD_MIN_MS &&
             rsp.next_period_ms <= mscdt_pkg::PERIOD_MAX_MS))
        else $error("next period out of range");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind multi_slot_countdown_timer mscdt_checker u_mscdt_checker (.*);

// ===== test/testbench.sv =====
// Self-checking bench for multi_slot_countdown_timer: directed corner cases, then random traffic.
// Keeps its own slot table to predict every response; depends on mscdt_pkg and the timer RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int SLOTS        = 8;
    localparam int RANDOM_COUNT = 236;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 30;
    localparam int IDLE_PCT     = 26;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_stall;
    mscdt_pkg::req_t req       = '0;
    logic            rsp_valid;
    logic            rsp_stall = 1'b0;
    mscdt_pkg::rsp_t rsp;

    // Predicted slot table and the responses it still owes
    mscdt_pkg::slot_t slot_tab [SLOTS];
    mscdt_pkg::rsp_t  responses_due [$];
    mscdt_pkg::rsp_t  due_rsp;

    bit          steady      = 1'b0;   // high: neither side idles
    int          mismatches  = 0;
    int          checked     = 0;
    int          expiries    = 0;
    int          cycle_count = 0;
    int          cmd_count [4] = '{default: 0};
    logic [63:0] wall_ms;

    multi_slot_countdown_timer #(.SLOTS(SLOTS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int s = 0; s < SLOTS; s++)
            slot_tab[s] = mscdt_pkg::SLOT_RESET;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // min over running slots of remaining/10, clamped; 0 when nothing runs
    function automatic logic [9:0] tick_period();
        logic [31:0] best;
        logic [31:0] d;
        best = '0;
        for (int s = 0; s < SLOTS; s++)
        begin
            if (slot_tab[s].channel != mscdt_pkg::FREE_CHANNEL && slot_tab[s].remaining != 0)
            begin
                d = slot_tab[s].remaining / 10;
                if (d < mscdt_pkg::PERIOD_MIN_MS)
                    d = mscdt_pkg::PERIOD_MIN_MS;
                else if (d > mscdt_pkg::PERIOD_MAX_MS)
                    d = mscdt_pkg::PERIOD_MAX_MS;
                if (best == 0 || d < best)
                    best = d;
            end
        end
        return best[9:0];
    endfunction

    // Update the slot table for one accepted request and queue its responses
    function automatic void apply_timer_command(input mscdt_pkg::req_t r);
        mscdt_pkg::rsp_t fin;
        mscdt_pkg::rsp_t ev;
        int              hit;
        logic [63:0]     gap;
        fin      = '0;
        fin.last = 1'b1;
        hit      = -1;
        case (r.command)
            mscdt_pkg::CMD_ARM:
            begin
                // same channel first, else the first free slot
                for (int s = 0; s < SLOTS && hit < 0; s++)
                    if (slot_tab[s].channel == r.channel)
                        hit = s;
                for (int s = 0; s < SLOTS && hit < 0; s++)
                    if (slot_tab[s].channel == mscdt_pkg::FREE_CHANNEL)
                        hit = s;
                if (hit >= 0)
                begin
                    slot_tab[hit].channel   = r.channel;
                    slot_tab[hit].remaining = r.duration_ms;
                    slot_tab[hit].stamp     = r.now_ms;
                    slot_tab[hit].pin       = r.gpio;
                    slot_tab[hit].target    = r.target_word;
                    slot_tab[hit].sender    = r.requester;
                end
                fin.kind = mscdt_pkg::KIND_ARM;
                fin.ok   = (hit >= 0);
            end
            mscdt_pkg::CMD_DISARM:
            begin
                for (int s = 0; s < SLOTS && hit < 0; s++)
                begin
                    if (slot_tab[s].channel == r.channel)
                    begin
                        hit = s;
                        slot_tab[s].channel = mscdt_pkg::FREE_CHANNEL;
                        if (slot_tab[s].remaining != 0)
                        begin
                            slot_tab[s].remaining = '0;
                            fin.ok = 1'b1;
                        end
                    end
                end
                fin.kind = mscdt_pkg::KIND_DISARM;
            end
            mscdt_pkg::CMD_TICK:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (slot_tab[s].channel != mscdt_pkg::FREE_CHANNEL
                        && slot_tab[s].remaining != 0)
                    begin
                        // modulo 2^64: time going backwards gives a huge gap
                        gap = r.now_ms - slot_tab[s].stamp;
                        if (gap >= {32'd0, slot_tab[s].remaining})
                        begin
                            slot_tab[s].remaining = '0;
                            ev             = '0;
                            ev.kind        = mscdt_pkg::KIND_EXPIRY;
                            ev.out_channel = slot_tab[s].channel;
                            ev.out_gpio    = slot_tab[s].pin;
                            ev.out_target  = slot_tab[s].target;
                            responses_due.push_back(ev);
                        end
                        else
                        begin
                            slot_tab[s].remaining = slot_tab[s].remaining - gap[31:0];
                        end
                        slot_tab[s].stamp = r.now_ms;
                        if (slot_tab[s].remaining == 0)
                            slot_tab[s].channel = mscdt_pkg::FREE_CHANNEL;
                    end
                end
                fin.kind = mscdt_pkg::KIND_TICK;
            end
            default:
            begin
                // query reports the last matching slot
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (slot_tab[s].channel == r.channel)
                    begin
                        fin.remaining_ms  = slot_tab[s].remaining;
                        fin.out_requester = slot_tab[s].sender;
                        fin.out_target    = slot_tab[s].target;
                    end
                end
                fin.kind        = mscdt_pkg::KIND_QUERY;
                fin.out_channel = r.channel;
            end
        endcase
        fin.next_period_ms = tick_period();
        responses_due.push_back(fin);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one request; valid stays up afterwards unless the next call idles first
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [7:0] pin, input logic [31:0] dur,
                                input logic [63:0] tgt, input logic signed [31:0] snd,
                                input logic [63:0] now);
        mscdt_pkg::req_t r;
        r.command     = cmd;
        r.channel     = ch;
        r.gpio        = pin;
        r.duration_ms = dur;
        r.target_word = tgt;
        r.requester   = snd;
        r.now_ms      = now;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        apply_timer_command(r);
        cmd_count[cmd]++;
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall, in-order check against the predictions
    // ------------------------------------------------------------------

    always @(posedge clk)
        rsp_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (responses_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: kind %0d channel %0d last %0d",
                             rsp.kind, rsp.out_channel, rsp.last);
            end
            else
            begin
                due_rsp = responses_due.pop_front();
                checked++;
                if (due_rsp.kind == mscdt_pkg::KIND_EXPIRY)
                    expiries++;
                if (rsp.kind !== due_rsp.kind || rsp.ok !== due_rsp.ok
                    || rsp.out_channel !== due_rsp.out_channel
                    || rsp.out_gpio !== due_rsp.out_gpio
                    || rsp.out_target !== due_rsp.out_target
                    || rsp.out_requester !== due_rsp.out_requester
                    || rsp.remaining_ms !== due_rsp.remaining_ms
                    || rsp.next_period_ms !== due_rsp.next_period_ms
                    || rsp.last !== due_rsp.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("response %0d mismatch (exp/got): kind %0d/%0d ok %0d/%0d",
                                 checked, due_rsp.kind, rsp.kind, due_rsp.ok, rsp.ok);
                        $display("  channel %0d/%0d gpio %0d/%0d target %h/%h",
                                 due_rsp.out_channel, rsp.out_channel,
                                 due_rsp.out_gpio, rsp.out_gpio,
                                 due_rsp.out_target, rsp.out_target);
                        $display("  requester %0d/%0d remaining %0d/%0d",
                                 due_rsp.out_requester, rsp.out_requester,
                                 due_rsp.remaining_ms, rsp.remaining_ms);
                        $display("  period %0d/%0d last %0d/%0d",
                                 due_rsp.next_period_ms, rsp.next_period_ms,
                                 due_rsp.last, rsp.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still owed",
                     cycle_count, responses_due.size());
            $display("multi_slot_countdown_timer regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing armed: query and disarm miss, tick reports period 0
    task automatic test_empty_table();
        send_request(mscdt_pkg::CMD_QUERY,  8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
        send_request(mscdt_pkg::CMD_DISARM, 8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
        send_request(mscdt_pkg::CMD_TICK,   8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
    endtask

    // Arm on the free channel keeps the slot free and unticked; zero duration never runs
    task automatic test_free_channel_and_zero_duration();
        send_request(mscdt_pkg::CMD_ARM, mscdt_pkg::FREE_CHANNEL, 8'hFF, 32'd1234, '1,
                     32'sh8000_0000, 64'd0);
        send_request(mscdt_pkg::CMD_QUERY, mscdt_pkg::FREE_CHANNEL, 8'd0, 32'd0, 64'd0,
                     32'sd0, 64'd0);
        send_request(mscdt_pkg::CMD_TICK, 8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd5000);
        send_request(mscdt_pkg::CMD_DISARM, mscdt_pkg::FREE_CHANNEL, 8'd0, 32'd0, 64'd0,
                     32'sd0, 64'd0);
        send_request(mscdt_pkg::CMD_ARM, 8'd7, 8'd0, 32'd0, 64'h0123_4567_89AB_CDEF,
                     32'sh7FFF_FFFF, 64'd5000);
        send_request(mscdt_pkg::CMD_QUERY, 8'd7, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
        // taken but not running: freed with ok low
        send_request(mscdt_pkg::CMD_DISARM, 8'd7, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
    endtask

    // Fill all slots, overflow, then re-arm an existing channel in place
    task automatic test_table_full();
        logic [7:0][31:0] durs;
        durs = {32'd499, 32'hFFFF_FFFF, 32'd20000, 32'd5000,
                32'd600, 32'd450, 32'd100, 32'd0};
        for (int k = 0; k < SLOTS; k++)
            send_request(mscdt_pkg::CMD_ARM, 8'(k), 8'(k * 37), durs[k],
                         {$urandom, $urandom}, $urandom, 64'd1000);
        send_request(mscdt_pkg::CMD_ARM, 8'd8, 8'd1, 32'd100, 64'd1, 32'sd1, 64'd1000);
        send_request(mscdt_pkg::CMD_ARM, 8'd3, 8'd2, 32'd300, 64'd2, 32'sd2, 64'd1100);
        send_request(mscdt_pkg::CMD_QUERY, 8'd3, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
    endtask

    // Ticks: some slots expire, then time goes backwards and expires the rest
    task automatic test_tick_expiry();
        send_request(mscdt_pkg::CMD_TICK, 8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd1450);
        send_request(mscdt_pkg::CMD_TICK, 8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, 64'd0);
        send_request(mscdt_pkg::CMD_TICK, 8'd0, 8'd0, 32'd0, 64'd0, 32'sd0, '1);
    endtask

    // Mostly a small channel pool and a steadily advancing clock, so slots fill,
    // run down and expire; a few wild channels, durations and time jumps mixed in
    task automatic test_random_traffic();
        logic [1:0]  cmd;
        logic [7:0]  ch;
        logic [31:0] dur;
        logic [63:0] now;
        int          pick;
        wall_ms = {32'd0, $urandom};
        for (int n = 0; n < RANDOM_COUNT; n++)
        begin
            steady = (n >= 110 && n < 170);
            pick = $urandom_range(99);
            if (pick < 35)
                cmd = mscdt_pkg::CMD_ARM;
            else if (pick < 50)
                cmd = mscdt_pkg::CMD_DISARM;
            else if (pick < 80)
                cmd = mscdt_pkg::CMD_TICK;
            else
                cmd = mscdt_pkg::CMD_QUERY;
            pick = $urandom_range(99);
            if (pick < 80)
                ch = 8'($urandom_range(11));
            else if (pick < 85)
                ch = mscdt_pkg::FREE_CHANNEL;
            else
                ch = 8'($urandom_range(255));
            pick = $urandom_range(99);
            if (pick < 10)
                dur = 32'd0;
            else if (pick < 70)
                dur = $urandom_range(3000);
            else if (pick < 80)
                dur = $urandom_range(20000, 3000);
            else
                dur = $urandom;
            if (cmd == mscdt_pkg::CMD_TICK)
                wall_ms = wall_ms + $urandom_range(800);
            pick = $urandom_range(99);
            if (pick < 90)
                now = wall_ms;
            else if (pick < 95)
                now = wall_ms - $urandom_range(2000);
            else
                now = {$urandom, $urandom};
            send_request(cmd, ch, 8'($urandom_range(255)), dur, {$urandom, $urandom},
                         $urandom, now);
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_free_channel_and_zero_duration();
        test_table_full();
        test_tick_expiry();
        test_random_traffic();

        req_valid <= 1'b0;
        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d requests: %0d arm, %0d disarm, %0d tick, %0d query",
                 cmd_count[mscdt_pkg::CMD_ARM] + cmd_count[mscdt_pkg::CMD_DISARM]
                 + cmd_count[mscdt_pkg::CMD_TICK] + cmd_count[mscdt_pkg::CMD_QUERY],
                 cmd_count[mscdt_pkg::CMD_ARM], cmd_count[mscdt_pkg::CMD_DISARM],
                 cmd_count[mscdt_pkg::CMD_TICK], cmd_count[mscdt_pkg::CMD_QUERY]);
        $display("checked %0d responses (%0d expiries), %0d mismatches",
                 checked, expiries, mismatches);
        if (mismatches == 0 && responses_due.size() == 0)
            $display("multi_slot_countdown_timer regression: pass");
        else
            $display("multi_slot_countdown_timer regression: fail");
        $finish;
    end

endmodule
